// ----- rtl/continued_fraction_expander_top_assert.svh -----
// ----------------------------------------------------------------------------
// Continued fraction expander assertion macros
// Implication checks on the block clock, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef CONTINUED_FRACTION_EXPANDER_TOP_ASSERT_SVH
`define CONTINUED_FRACTION_EXPANDER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CFE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfe assertion failed");
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfe assertion failed");
`else
`define CFE_ASSERT_SAME(label, clk, rst, ante, cons)
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/cfe_pkg.sv -----
// ----------------------------------------------------------------------------
// Continued fraction expander package
// Widths, limits, status codes and item types shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

  localparam int FIELD_W   = 32;
  localparam int WIDTH     = 32;
  localparam int STATUS_W  = 2;
  localparam int MAX_TERMS = 47;
  localparam int BIT_CNT_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int TERM_CNT_W = $clog2(MAX_TERMS);

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] numerator;
    logic [FIELD_W-1:0] denominator;
  } cfe_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  term;
    logic [STATUS_W-1:0] status;
    logic                last;
  } cfe_out_t;

endpackage

`default_nettype wire

// ----- rtl/cfe_div.sv -----
// ----------------------------------------------------------------------------
// Continued fraction expander divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfe_div
  import cfe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder
);

  logic                 busy;
  logic [BIT_CNT_W-1:0] cnt;
  logic [WIDTH-1:0]     qsh;
  logic [WIDTH-1:0]     rem;
  logic [WIDTH-1:0]     dvs;
  logic [WIDTH:0]       rem_sh;
  logic [WIDTH:0]       diff;
  logic                 qbit;

  always_comb begin
    rem_sh = {rem, qsh[WIDTH-1]};
    diff   = rem_sh - {1'b0, dvs};
    qbit   = ~diff[WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= BIT_CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsh <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      qsh <= {qsh[WIDTH-2:0], qbit};
      rem <= qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    end
  end

  assign quotient  = qsh;
  assign remainder = rem;

endmodule

`default_nettype wire

// ----- rtl/continued_fraction_expander_top.sv -----
// ----------------------------------------------------------------------------
// Continued fraction expander top level
// Expands numerator/denominator into partial quotients by Euclid's algorithm.
// ----------------------------------------------------------------------------
// Each term comes from the bit-serial divider, awaited in the S_DIV state.
// An item yields up to 47 terms.
// Zero denominator or numerator below denominator: one result, in the cycle after acceptance.
// A result waits in the output register; the next term starts once it is taken.
// Reset (rst, synchronous) returns the sequencer to idle and drops any item.
`timescale 1ns / 1ps
`default_nettype none
`include "continued_fraction_expander_top_assert.svh"

module continued_fraction_expander_top
  import cfe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     frac_valid,
  output logic          frac_stall,
  input  wire cfe_in_t  frac,
  output logic          term_valid,
  input  wire logic     term_stall,
  output cfe_out_t      result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]            state;
  logic [WIDTH-1:0]      n_reg;
  logic [WIDTH-1:0]      d_reg;
  logic [TERM_CNT_W-1:0] term_cnt;

  logic [WIDTH-1:0] in_n;
  logic [WIDTH-1:0] in_d;
  logic             frac_acc;
  logic             term_acc;
  logic             div_start;
  logic [WIDTH-1:0] div_n;
  logic [WIDTH-1:0] div_d;
  logic             div_done;
  logic [WIDTH-1:0] div_q;
  logic [WIDTH-1:0] div_r;
  logic             final_term;

  assign in_n       = frac.numerator[WIDTH-1:0];
  assign in_d       = frac.denominator[WIDTH-1:0];
  assign frac_stall = (state != S_IDLE);
  assign term_valid = (state == S_EMIT);
  assign frac_acc   = frac_valid && !frac_stall;
  assign term_acc   = term_valid && !term_stall;
  assign final_term = (div_r == '0) || (term_cnt == TERM_CNT_W'(MAX_TERMS - 1));

  always_comb begin
    div_start = 1'b0;
    div_n     = n_reg;
    div_d     = d_reg;
    if (state == S_IDLE) begin
      div_n     = in_n;
      div_d     = in_d;
      div_start = frac_acc && (in_d != '0) && !(in_n < in_d);
    end else if (state == S_EMIT) begin
      div_start = term_acc && !result.last;
    end
  end

  cfe_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      term_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (frac_acc) begin
            term_cnt <= '0;
            state    <= div_start ? S_DIV : S_EMIT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (term_acc) begin
            term_cnt <= term_cnt + 1'b1;
            state    <= result.last ? S_IDLE : S_DIV;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && frac_acc) begin
      n_reg <= in_n;
      d_reg <= in_d;
      result.term <= '0;
      result.last <= 1'b1;
      result.status <= (in_d == '0) ? ST_ZERO_DEN : ST_EMPTY;
    end else if (state == S_DIV && div_done) begin
      n_reg <= d_reg;
      d_reg <= div_r;
      result.term   <= FIELD_W'(div_q);
      result.status <= ST_OK;
      result.last   <= final_term;
    end
  end

  `CFE_ASSERT_SAME(a_err_shape, clk, rst, term_valid && (result.status != ST_OK),
                   (result.term == '0) && result.last)
  `CFE_ASSERT_SAME(a_done_in_div, clk, rst, div_done, state == S_DIV)
  `CFE_ASSERT_NEXT(a_accept_blocks, clk, rst, frac_acc, frac_stall)
  `CFE_ASSERT_SAME(a_cap_last, clk, rst,
                   term_valid && (term_cnt == TERM_CNT_W'(MAX_TERMS - 1)), result.last)

endmodule

`default_nettype wire

// ----- bench/continued_fraction_expander_checker.sv -----
// ----------------------------------------------------------------------------
// Continued fraction expander checker
// Watches both channels of the expander, predicts the partial quotients of
// every accepted fraction by Euclid's algorithm and compares them, in order,
// with the terms the block hands out. Reports the mismatch count and the
// number of terms still owed to the top of the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module continued_fraction_expander_checker
  import cfe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     frac_valid,
  input  wire logic     frac_stall,
  input  wire cfe_in_t  frac,
  input  wire logic     term_valid,
  input  wire logic     term_stall,
  input  wire cfe_out_t result,
  output int            mismatches,
  output int            pending
);

  cfe_out_t expected_terms[$];
  int       terms_seen;

  initial begin
    mismatches = 0;
    pending    = 0;
    terms_seen = 0;
  end

  function automatic void expand_fraction(input cfe_in_t item);
    logic [WIDTH-1:0] n;
    logic [WIDTH-1:0] d;
    logic [WIDTH-1:0] r;
    cfe_out_t         res;
    int               count;
    n     = WIDTH'(item.numerator);
    d     = WIDTH'(item.denominator);
    count = 0;
    res   = '0;
    if (d == '0) begin
      res.status = ST_ZERO_DEN;
      res.last   = 1'b1;
      expected_terms.push_back(res);
    end else if (n < d) begin
      res.status = ST_EMPTY;
      res.last   = 1'b1;
      expected_terms.push_back(res);
    end else begin
      while (!res.last) begin
        r          = n % d;
        res.term   = FIELD_W'(n / d);
        res.status = ST_OK;
        count++;
        // cut the expansion off at the term limit
        res.last   = (r == '0) || (count == MAX_TERMS);
        expected_terms.push_back(res);
        n = d;
        d = r;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("%0t checker: term %0d %s: got %0h, expected %0h",
               $realtime, terms_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cfe_out_t want;
    if (!rst) begin
      if (frac_valid && !frac_stall)
        expand_fraction(frac);
      if (term_valid && !term_stall) begin
        if (expected_terms.size() == 0) begin
          report_mismatch("arrived with nothing owed", result, 64'd0);
        end else begin
          want = expected_terms.pop_front();
          if (result.term !== want.term)
            report_mismatch("quotient", result.term, want.term);
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
          if (result.last !== want.last)
            report_mismatch("last flag", result.last, want.last);
        end
        terms_seen++;
      end
      pending = expected_terms.size();
    end
  end

endmodule

// ----- bench/continued_fraction_expander_top_test.sv -----
// ----------------------------------------------------------------------------
// Continued fraction expander testbench
// Feeds directed and random fractions into the expander under three idling
// mixes on the two channels, lets the checker predict and compare every term,
// and prints the verdict once all terms have come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module continued_fraction_expander_top_test;
  import cfe_pkg::*;

  localparam int RANDOM_FRACS = 330;
  localparam int PHASES       = 3;

  logic     clk;
  logic     rst;
  logic     frac_valid;
  logic     frac_stall;
  cfe_in_t  frac;
  logic     term_valid;
  logic     term_stall;
  cfe_out_t result;
  int       mismatches;
  int       pending;
  int       send_idle_pct;
  int       recv_idle_pct;

  continued_fraction_expander_top dut (
    .clk        (clk),
    .rst        (rst),
    .frac_valid (frac_valid),
    .frac_stall (frac_stall),
    .frac       (frac),
    .term_valid (term_valid),
    .term_stall (term_stall),
    .result     (result)
  );

  continued_fraction_expander_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .frac_valid (frac_valid),
    .frac_stall (frac_stall),
    .frac       (frac),
    .term_valid (term_valid),
    .term_stall (term_stall),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("continued_fraction_expander_top_test: done, errors");
    $finish;
  end

  initial begin
    term_stall = 1'b0;
    forever begin
      @(negedge clk);
      term_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_frac(input cfe_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      frac_valid <= 1'b0;
      @(negedge clk);
    end
    frac_valid <= 1'b1;
    frac       <= item;
    @(posedge clk);
    while (frac_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_ratio(input logic [31:0] n, input logic [31:0] d);
    cfe_in_t item;
    item.numerator   = n;
    item.denominator = d;
    send_frac(item);
  endtask

  task automatic drain_terms();
    frac_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic cfe_in_t random_ratio();
    cfe_in_t     item;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    int          kind;
    int          k;
    kind             = $urandom_range(0, 99);
    item.numerator   = $urandom;
    item.denominator = $urandom;
    if (kind < 6) begin
      item.denominator = '0;
      if (kind < 2) item.numerator = '0;
    end else if (kind < 14) begin
      if (item.denominator == '0) item.denominator = 32'd1;
      item.numerator = $urandom % item.denominator;
    end else if (kind < 26) begin
      // consecutive Fibonacci numbers give the longest expansions
      a = 32'd1;
      b = 32'd1;
      k = $urandom_range(1, 45);
      repeat (k) begin
        t = a + b;
        a = b;
        b = t;
      end
      item.numerator   = b;
      item.denominator = a;
    end else begin
      if (kind < 45) begin
        item.numerator   = $urandom_range(0, 4095);
        item.denominator = $urandom_range(1, 4095);
      end else begin
        item.numerator   = $urandom >> $urandom_range(0, 31);
        item.denominator = $urandom >> $urandom_range(0, 31);
        if (item.denominator == '0) item.denominator = 32'd1;
      end
      if (item.numerator < item.denominator && $urandom_range(0, 9) != 0) begin
        t                = item.numerator;
        item.numerator   = item.denominator;
        item.denominator = t;
      end
    end
    return item;
  endfunction

  initial begin
    send_idle_pct = 10;
    recv_idle_pct = 75;
    rst        = 1'b1;
    frac_valid = 1'b0;
    frac       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_ratio(32'd0, 32'd0);
    send_ratio(32'hFFFF_FFFF, 32'd0);
    send_ratio(32'd0, 32'd1);
    send_ratio(32'd1, 32'hFFFF_FFFF);
    send_ratio(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_ratio(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ratio(32'hFFFF_FFFF, 32'd1);
    send_ratio(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_ratio(32'h8000_0000, 32'h7FFF_FFFF);
    send_ratio(32'hAAAA_AAAA, 32'h5555_5555);
    send_ratio(32'h5555_5555, 32'hAAAA_AAAA);
    send_ratio(32'd2971215073, 32'd1836311903);
    send_ratio(32'd1836311903, 32'd1134903170);
    send_ratio(32'd355, 32'd113);
    send_ratio(32'd7, 32'd3);
    send_ratio(32'd1, 32'd1);
    send_ratio(32'd5, 32'd5);
    send_ratio(32'd12, 32'd4);
    send_ratio(32'd3, 32'd7);
    send_ratio(32'hFFFF_FFFF, 32'h8000_0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_terms();
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 10 : 0;
      for (int i = 0; i < RANDOM_FRACS / PHASES; i++)
        send_frac(random_ratio());
    end

    drain_terms();
    repeat (100) @(negedge clk);
    if (mismatches == 0)
      $display("continued_fraction_expander_top_test: done, clean");
    else
      $display("continued_fraction_expander_top_test: done, errors");
    $finish;
  end

endmodule
